>>> design/assert_macros.svh
// Shared assertion macros for the splat block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sks_pkg.sv
package sks_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int RAM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_ADDR_W = 4;

    localparam logic [8:0] WIDTH_RESET  = 9'd256;
    localparam logic [8:0] HEIGHT_RESET = 9'd256;
    localparam logic       LARGE_RESET  = 1'b0;
    localparam logic [7:0] GLOW_RESET   = 8'd191;

    localparam logic [7:0] LEVEL_MAX = 8'd255;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_LARGE  = 2'd2,
        REG_GLOW   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_SPLAT = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [8:0] width;
        logic [8:0] height;
        logic       large_kernel;
        logic [7:0] glow_top;
    } cfg_t;

    // One classified request as it waits between front and back.
    typedef struct packed {
        cmd_t       kind;
        logic [7:0] x;
        logic [7:0] y;
        logic       wide;
        logic [8:0] w_eff;
        logic [8:0] h_eff;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic init_busy;
    } back_stat_t;

    typedef struct packed {
        logic       last;
        logic       touched;
        logic [7:0] pixel_value;
        logic [7:0] level;
        logic [7:0] row;
        logic [7:0] col;
    } res_t;

    localparam logic [6:0] KERN3 [3][3] = '{
        '{7'd4, 7'd8,  7'd4},
        '{7'd8, 7'd64, 7'd8},
        '{7'd4, 7'd8,  7'd4}
    };

    localparam logic [6:0] KERN7 [7][7] = '{
        '{7'd0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd0},
        '{7'd1, 7'd1, 7'd1, 7'd2, 7'd1, 7'd1, 7'd1},
        '{7'd1, 7'd1, 7'd2, 7'd4, 7'd2, 7'd1, 7'd1},
        '{7'd1, 7'd2, 7'd4, 7'd6, 7'd4, 7'd2, 7'd1},
        '{7'd1, 7'd1, 7'd2, 7'd4, 7'd2, 7'd1, 7'd1},
        '{7'd1, 7'd1, 7'd1, 7'd2, 7'd1, 7'd1, 7'd1},
        '{7'd0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd0}
    };

    // Weight of kernel cell (ky, kx); cells beyond the kernel weigh zero.
    function automatic logic [6:0] kernel_weight(input logic wide,
                                                 input logic [2:0] ky,
                                                 input logic [2:0] kx);
        logic [6:0] wt;
        wt = 7'd0;
        if (wide)
        begin
            if (ky < 3'd7 && kx < 3'd7)
            begin
                wt = KERN7[ky][kx];
            end
        end
        else
        begin
            if (ky < 3'd3 && kx < 3'd3)
            begin
                wt = KERN3[ky[1:0]][kx[1:0]];
            end
        end
        return wt;
    endfunction

endpackage

>>> design/sks_ram.sv
module sks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sks_queue.sv
module sks_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sks_pkg::entry_t   push_data,
    input  logic              pop,
    output sks_pkg::entry_t   head,
    output sks_pkg::q_stat_t  stat
);

    sks_pkg::entry_t                 slot_reg [sks_pkg::Q_DEPTH];
    logic [sks_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [sks_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [sks_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [sks_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [sks_pkg::Q_CNT_W-1:0]     count_reg;
    logic [sks_pkg::Q_CNT_W-1:0]     count_next;

    function automatic logic [sks_pkg::Q_PTR_W-1:0] bump(
        input logic [sks_pkg::Q_PTR_W-1:0] p);
        logic [sks_pkg::Q_PTR_W-1:0] n;
        if (p == sks_pkg::Q_PTR_W'(sks_pkg::Q_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == sks_pkg::Q_CNT_W'(sks_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

>>> design/sks_front.sv
module sks_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // x [7:0], y [15:8]
    input  logic                 s_tuser,   // command [0]
    input  sks_pkg::cfg_t        cfg,
    input  sks_pkg::back_stat_t  bstat,
    input  sks_pkg::q_stat_t     qstat,
    output logic                 push,
    output sks_pkg::entry_t      push_data
);

    logic             hold_valid_reg;
    logic             hold_valid_next;
    sks_pkg::entry_t  hold_reg;
    sks_pkg::entry_t  entry;
    logic             accept;

    // Geometry is clamped here, so the back end only compares.
    always_comb
    begin
        entry.kind  = s_tuser ? sks_pkg::CMD_CLEAR : sks_pkg::CMD_SPLAT;
        entry.x     = s_tdata[7:0];
        entry.y     = s_tdata[15:8];
        entry.wide  = cfg.large_kernel;
        entry.w_eff = (32'(cfg.width) > sks_pkg::MAX_WIDTH)
                      ? 9'(sks_pkg::MAX_WIDTH) : cfg.width;
        entry.h_eff = (32'(cfg.height) > sks_pkg::MAX_HEIGHT)
                      ? 9'(sks_pkg::MAX_HEIGHT) : cfg.height;
    end

    assign s_tready = !bstat.init_busy && (!hold_valid_reg || !qstat.full);
    assign accept   = s_tvalid && s_tready;
    assign push     = hold_valid_reg && !qstat.full;
    assign push_data = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= entry;
        end
    end

endmodule

>>> design/sks_back.sv
`include "assert_macros.svh"

module sks_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           glow_top,
    input  sks_pkg::entry_t      head,
    input  sks_pkg::q_stat_t     qstat,
    output logic                 pop,
    output sks_pkg::back_stat_t  bstat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output sks_pkg::res_t        m_res
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_CLEAR,
        ST_FLUSH
    } state_t;

    state_t                        state_reg, state_next;
    logic [sks_pkg::ADDR_W-1:0]    sweep_reg, sweep_next;
    logic [2:0]                    ky_reg, ky_next;
    logic [2:0]                    kx_reg, kx_next;
    sks_pkg::entry_t               item_reg, item_next;

    logic                          b_valid_reg, b_valid_next;
    logic [7:0]                    b_col_reg, b_col_next;
    logic [7:0]                    b_row_reg, b_row_next;
    logic [sks_pkg::ADDR_W-1:0]    b_addr_reg, b_addr_next;
    logic [6:0]                    b_wt_reg, b_wt_next;

    logic                          p_valid_reg, p_valid_next;
    logic [7:0]                    p_col_reg, p_col_next;
    logic [7:0]                    p_row_reg, p_row_next;
    logic [7:0]                    p_level_reg, p_level_next;
    logic [7:0]                    p_pix_reg, p_pix_next;

    logic                          o_valid_reg, o_valid_next;
    sks_pkg::res_t                 o_res_reg, o_res_next;

    logic                          ram_we, ram_re;
    logic [sks_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [7:0]                    ram_wdata, ram_rdata;

    logic                          o_free, b_go, fin_load;
    logic [8:0]                    sum;
    logic [7:0]                    new_level;
    logic [15:0]                   prod;
    logic [2:0]                    rad, kmax;
    logic [9:0]                    cell_c, cell_r;
    logic [6:0]                    cell_wt;
    logic                          cell_hit, cell_last;
    logic [sks_pkg::ADDR_W-1:0]    cell_addr;

    sks_ram #(
        .WIDTH(8),
        .DEPTH(sks_pkg::RAM_DEPTH)
    ) u_plane (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Kernel cell under the walker. Offsets are taken modulo 2^10, so a
    // point left of or above the origin shows up with bit 9 set.
    always_comb
    begin
        rad       = item_reg.wide ? 3'd3 : 3'd1;
        kmax      = item_reg.wide ? 3'd6 : 3'd2;
        cell_wt   = sks_pkg::kernel_weight(item_reg.wide, ky_reg, kx_reg);
        cell_c    = 10'(item_reg.x) + 10'(kx_reg) - 10'(rad);
        cell_r    = 10'(item_reg.y) + 10'(ky_reg) - 10'(rad);
        cell_hit  = (cell_wt != 7'd0)
                    && !cell_c[9] && (cell_c[8:0] < item_reg.w_eff)
                    && !cell_r[9] && (cell_r[8:0] < item_reg.h_eff);
        cell_last = (ky_reg == kmax) && (kx_reg == kmax);
        cell_addr = sks_pkg::ADDR_W'(cell_r[8:0]) * sks_pkg::ADDR_W'(sks_pkg::MAX_WIDTH)
                    + sks_pkg::ADDR_W'(cell_c[8:0]);
    end

    always_comb
    begin
        sum       = {1'b0, ram_rdata} + 9'(b_wt_reg);
        new_level = sum[8] ? sks_pkg::LEVEL_MAX : sum[7:0];
        prod      = 16'(new_level) * 16'(glow_top);
    end

    assign o_free   = !o_valid_reg || m_tready;
    // The newest result waits in the pending register until it is known
    // whether another one follows, which decides its last flag.
    assign b_go     = b_valid_reg && (!p_valid_reg || o_free);
    assign fin_load = (state_reg == ST_FLUSH) && !b_valid_reg && o_free;

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        ky_next      = ky_reg;
        kx_next      = kx_reg;
        item_next    = item_reg;
        b_valid_next = b_valid_reg;
        b_col_next   = b_col_reg;
        b_row_next   = b_row_reg;
        b_addr_next  = b_addr_reg;
        b_wt_next    = b_wt_reg;
        p_valid_next = p_valid_reg;
        p_col_next   = p_col_reg;
        p_row_next   = p_row_reg;
        p_level_next = p_level_reg;
        p_pix_next   = p_pix_reg;
        o_valid_next = o_valid_reg;
        o_res_next   = o_res_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = b_addr_reg;
        ram_wdata    = new_level;
        ram_re       = 1'b0;
        ram_raddr    = cell_addr;

        if (o_valid_reg && m_tready)
        begin
            o_valid_next = 1'b0;
        end

        if (b_go)
        begin
            ram_we       = 1'b1;
            b_valid_next = 1'b0;
            p_valid_next = 1'b1;
            p_col_next   = b_col_reg;
            p_row_next   = b_row_reg;
            p_level_next = new_level;
            p_pix_next   = prod[15:8];
            if (p_valid_reg)
            begin
                o_valid_next = 1'b1;
                o_res_next   = '{last: 1'b0, touched: 1'b1, pixel_value: p_pix_reg,
                                 level: p_level_reg, row: p_row_reg, col: p_col_reg};
            end
        end

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = 8'd0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == sks_pkg::ADDR_W'(sks_pkg::RAM_DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FLUSH;
                end
            end
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    item_next  = head;
                    ky_next    = 3'd0;
                    kx_next    = 3'd0;
                    state_next = (head.kind == sks_pkg::CMD_CLEAR) ? ST_CLEAR : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!cell_hit || !b_valid_reg || b_go)
                begin
                    if (cell_hit)
                    begin
                        ram_re       = 1'b1;
                        b_valid_next = 1'b1;
                        b_col_next   = cell_c[7:0];
                        b_row_next   = cell_r[7:0];
                        b_addr_next  = cell_addr;
                        b_wt_next    = cell_wt;
                    end
                    if (cell_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (kx_reg == kmax)
                    begin
                        kx_next = 3'd0;
                        ky_next = ky_reg + 3'd1;
                    end
                    else
                    begin
                        kx_next = kx_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (fin_load)
                begin
                    o_valid_next = 1'b1;
                    if (p_valid_reg)
                    begin
                        p_valid_next = 1'b0;
                        o_res_next   = '{last: 1'b1, touched: 1'b1, pixel_value: p_pix_reg,
                                         level: p_level_reg, row: p_row_reg,
                                         col: p_col_reg};
                    end
                    else
                    begin
                        o_res_next      = '0;
                        o_res_next.last = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            sweep_reg   <= '0;
            b_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            b_valid_reg <= b_valid_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ky_reg      <= ky_next;
        kx_reg      <= kx_next;
        item_reg    <= item_next;
        b_col_reg   <= b_col_next;
        b_row_reg   <= b_row_next;
        b_addr_reg  <= b_addr_next;
        b_wt_reg    <= b_wt_next;
        p_col_reg   <= p_col_next;
        p_row_reg   <= p_row_next;
        p_level_reg <= p_level_next;
        p_pix_reg   <= p_pix_next;
        o_res_reg   <= o_res_next;
    end

    assign bstat.init_busy = (state_reg == ST_INIT);
    assign m_tvalid        = o_valid_reg;
    assign m_res           = o_res_reg;

    `SKS_ASSERT_IMPL(a_sweep_no_rmw, clk, rst_n,
        (state_reg == ST_INIT || state_reg == ST_CLEAR), !b_valid_reg,
        "memory stage busy during a clearing sweep")
    `SKS_ASSERT_IMPL(a_rw_distinct, clk, rst_n,
        ram_re && ram_we, ram_raddr != ram_waddr,
        "read and write hit the same pixel in one cycle")
    `SKS_ASSERT_IMPL(a_pend_in_walk, clk, rst_n,
        p_valid_reg, (state_reg == ST_WALK || state_reg == ST_FLUSH),
        "pending result outside a splat")
    `SKS_ASSERT_NEXT(a_fin_idle, clk, rst_n,
        fin_load, (state_reg == ST_IDLE) && o_valid_reg && o_res_reg.last,
        "final result not followed by idle")

endmodule

>>> design/saturating_kernel_splat.sv
// Channel   | Direction | Signals                          | Content
// ----------+-----------+----------------------------------+-------------------------------
// s_        | in        | s_tvalid s_tready s_tdata s_tuser | splat or clear request
// m_        | out       | m_tvalid m_tready m_tdata m_tuser | one result per touched pixel
//           |           | m_tlast                          | or one empty result if none
// apb       | in/out    | psel penable pwrite paddr pwdata | width, height, kernel, glow
//           |           | prdata pready                    |
//
// A splat walks its 3x3 or 7x7 kernel one cell per cycle while m_ does not stall,
// set by the single read-modify-write port pair of the intensity memory. A clear
// sweeps all 65536 pixels of the memory one pixel a cycle. After reset the same
// sweep runs with s_tready low; configuration writes are taken throughout. A stall
// on m_ stops the memory stage; the input side keeps taking requests until its
// holding register and the two-entry queue are full.
module saturating_kernel_splat (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // x [7:0], y [15:8]
    input  logic                             s_tuser,   // command [0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // col, row, level, pixel_value
    output logic                             m_tuser,   // touched [0]
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sks_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [8:0]           width_reg;
    logic [8:0]           height_reg;
    logic                 large_reg;
    logic [7:0]           glow_reg;
    sks_pkg::cfg_t        cfg;
    sks_pkg::reg_idx_t    reg_idx;
    logic                 cfg_write;

    sks_pkg::back_stat_t  bstat;
    sks_pkg::q_stat_t     qstat;
    logic                 push, pop;
    sks_pkg::entry_t      push_data, head;
    sks_pkg::res_t        res;

    assign pready    = 1'b1;
    assign reg_idx   = sks_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sks_pkg::WIDTH_RESET;
            height_reg <= sks_pkg::HEIGHT_RESET;
            large_reg  <= sks_pkg::LARGE_RESET;
            glow_reg   <= sks_pkg::GLOW_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                sks_pkg::REG_WIDTH:  width_reg  <= pwdata[8:0];
                sks_pkg::REG_HEIGHT: height_reg <= pwdata[8:0];
                sks_pkg::REG_LARGE:  large_reg  <= pwdata[0];
                sks_pkg::REG_GLOW:   glow_reg   <= pwdata[7:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sks_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            sks_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            sks_pkg::REG_LARGE:  prdata = 32'(large_reg);
            sks_pkg::REG_GLOW:   prdata = 32'(glow_reg);
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.width        = width_reg;
    assign cfg.height       = height_reg;
    assign cfg.large_kernel = large_reg;
    assign cfg.glow_top     = glow_reg;

    sks_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg),
        .bstat     (bstat),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    sks_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    sks_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .glow_top (glow_reg),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .bstat    (bstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {res.pixel_value, res.level, res.row, res.col};
    assign m_tuser = res.touched;
    assign m_tlast = res.last;

endmodule
